// File: rtl/core/plst_pkg.sv
//------------------------------------------------------------------------------
// plst_pkg
// Shared types and codes for the positional list store.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plst_pkg;

  typedef enum logic [3:0] {
    OP_INSERT     = 4'd0,
    OP_ERASE      = 4'd1,
    OP_PUSH_FRONT = 4'd2,
    OP_PUSH_BACK  = 4'd3,
    OP_POP_FRONT  = 4'd4,
    OP_POP_BACK   = 4'd5,
    OP_FIND       = 4'd6,
    OP_MODIFY     = 4'd7,
    OP_READ       = 4'd8
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_FETCH,
    S_TAKE,
    S_PUT,
    S_FIN
  } state_t;

  localparam int POS_W  = 9;
  localparam int WORD_W = 32;

endpackage

`default_nettype wire

// File: rtl/core/plst_ifs.sv
//------------------------------------------------------------------------------
// plst_ifs
// Valid/ready channels for operation words and result words.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface plst_in_if;
  import plst_pkg::*;
  logic                valid;
  logic                ready;
  opcode_t             opcode;
  logic [POS_W-1:0]    position;
  logic [WORD_W-1:0]   value;

  modport source (output valid, output opcode, output position, output value,
                  input ready);
  modport sink   (input valid, input opcode, input position, input value,
                  output ready);
endinterface

interface plst_out_if;
  import plst_pkg::*;
  logic                valid;
  logic                ready;
  status_t             status;
  logic [POS_W-1:0]    found_position;
  logic [WORD_W-1:0]   element;
  logic [POS_W-1:0]    count;

  modport source (output valid, output status, output found_position,
                  output element, output count, input ready);
  modport sink   (input valid, input status, input found_position,
                  input element, input count, output ready);
endinterface

`default_nettype wire

// File: rtl/core/positional_list_store_core.sv
//------------------------------------------------------------------------------
// positional_list_store_core
// Ordered list of 32-bit words in a fixed store with a live count.
//------------------------------------------------------------------------------
// Usage:
//   in_ch carries one operation word (opcode, one-based position, value);
//   out_ch returns exactly one result word per operation (status, position,
//   element, count after the operation). Both are valid/ready channels.
//   in_ch.ready is high only while no operation is in progress; a result
//   that waits on out_ch does not hold off the next operation.
//   Insert, erase and find walk the store one entry per cycle, reading one
//   entry and writing or comparing the one read before.
// Reset: count goes to zero; store contents are left as they are and are
//   never read before being written.
// Stall: a result is held in the output register until taken; a finished
//   operation waits in its final state while an older result is pending.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module positional_list_store_core #(
  parameter int CAPACITY = 256
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  plst_in_if.sink     in_ch,
  plst_out_if.source  out_ch
);
  import plst_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  opcode_t           op_r, op_nxt;
  logic              up_r, up_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [AW-1:0]     ridx_r, ridx_nxt;
  logic [AW-1:0]     widx_r, widx_nxt;
  logic [CW-1:0]     rleft_r, rleft_nxt;
  logic              pend_r, pend_nxt;
  logic [WORD_W-1:0] val_r, val_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [POS_W-1:0]  res_pos_r, res_pos_nxt;
  logic [WORD_W-1:0] res_elem_r, res_elem_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [WORD_W-1:0] out_elem_r;
  logic [POS_W-1:0]  out_count_r;
  logic              load;

  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [WORD_W-1:0] wr_data, rd_data;

  logic              in_fire;
  logic [XW-1:0]     n_x, pos_x, tgt_x;
  logic [AW-1:0]     idx_a;
  logic              ins_ok, pos_ok;

  plst_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // target position, one-based
  assign n_x   = XW'(count_r);
  assign pos_x = XW'(in_ch.position);

  always_comb begin
    case (in_ch.opcode) inside
      OP_PUSH_FRONT, OP_POP_FRONT: tgt_x = XW'(1);
      OP_PUSH_BACK:                tgt_x = n_x + XW'(1);
      OP_POP_BACK:                 tgt_x = n_x;
      default:                     tgt_x = pos_x;
    endcase
  end

  assign idx_a  = AW'(tgt_x - XW'(1));
  assign ins_ok = (tgt_x != '0) && (tgt_x <= n_x + XW'(1));
  assign pos_ok = (tgt_x != '0) && (tgt_x <= n_x);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    op_nxt         = op_r;
    up_nxt         = up_r;
    idx_nxt        = idx_r;
    ridx_nxt       = ridx_r;
    widx_nxt       = widx_r;
    rleft_nxt      = rleft_r;
    pend_nxt       = pend_r;
    val_nxt        = val_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    res_elem_nxt   = res_elem_r;
    load           = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = widx_r;
    wr_data        = rd_data;
    rd_en          = 1'b0;
    rd_addr        = ridx_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt         = in_ch.opcode;
          val_nxt        = in_ch.value;
          idx_nxt        = idx_a;
          pend_nxt       = 1'b0;
          up_nxt         = 1'b0;
          res_status_nxt = ST_BAD;
          res_pos_nxt    = '0;
          res_elem_nxt   = '0;
          state_nxt      = S_FIN;
          case (in_ch.opcode) inside
            OP_INSERT, OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (ins_ok) begin
                if (count_r == FULL_CNT) begin
                  res_status_nxt = ST_FULL;
                end else begin
                  res_status_nxt = ST_OK;
                  res_pos_nxt    = POS_W'(tgt_x);
                  res_elem_nxt   = in_ch.value;
                  count_nxt      = count_r + CW'(1);
                  up_nxt         = 1'b1;
                  ridx_nxt       = AW'(n_x - XW'(1));
                  rleft_nxt      = CW'(n_x - XW'(idx_a));
                  state_nxt      = S_MOVE;
                end
              end
            end
            OP_ERASE, OP_POP_FRONT, OP_POP_BACK: begin
              if (pos_ok) begin
                res_status_nxt = ST_OK;
                res_pos_nxt    = POS_W'(tgt_x);
                count_nxt      = count_r - CW'(1);
                ridx_nxt       = AW'(tgt_x);
                rleft_nxt      = CW'(n_x - tgt_x);
                state_nxt      = S_FETCH;
              end
            end
            OP_FIND: begin
              res_status_nxt = ST_MISS;
              ridx_nxt       = '0;
              rleft_nxt      = count_r;
              state_nxt      = S_MOVE;
            end
            OP_MODIFY: begin
              if (pos_ok) begin
                res_status_nxt = ST_OK;
                res_pos_nxt    = POS_W'(tgt_x);
                res_elem_nxt   = in_ch.value;
                state_nxt      = S_PUT;
              end
            end
            OP_READ: begin
              if (pos_ok) begin
                res_status_nxt = ST_OK;
                res_pos_nxt    = POS_W'(tgt_x);
                state_nxt      = S_FETCH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // one read per cycle; the word read last cycle is written or compared
      S_MOVE: begin
        if (rleft_r != '0) begin
          rd_en     = 1'b1;
          pend_nxt  = 1'b1;
          rleft_nxt = rleft_r - CW'(1);
          if (up_r) begin
            widx_nxt = ridx_r + AW'(1);
            ridx_nxt = ridx_r - AW'(1);
          end else begin
            widx_nxt = (op_r == OP_FIND) ? ridx_r : ridx_r - AW'(1);
            ridx_nxt = ridx_r + AW'(1);
          end
        end else begin
          pend_nxt = 1'b0;
        end
        if (op_r == OP_FIND) begin
          if (pend_r && (rd_data == val_r)) begin
            res_status_nxt = ST_OK;
            res_pos_nxt    = POS_W'(XW'(widx_r) + XW'(1));
            res_elem_nxt   = val_r;
            pend_nxt       = 1'b0;
            state_nxt      = S_FIN;
          end else if ((rleft_r == '0) && !pend_r) begin
            state_nxt = S_FIN;
          end
        end else begin
          wr_en = pend_r;
          if ((rleft_r == '0) && !pend_r) begin
            state_nxt = up_r ? S_PUT : S_FIN;
          end
        end
      end

      S_FETCH: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r;
        state_nxt = S_TAKE;
      end

      S_TAKE: begin
        res_elem_nxt = rd_data;
        state_nxt    = (op_r == OP_READ) ? S_FIN : S_MOVE;
      end

      S_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r;
        wr_data   = val_r;
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    up_r         <= up_nxt;
    idx_r        <= idx_nxt;
    ridx_r       <= ridx_nxt;
    widx_r       <= widx_nxt;
    rleft_r      <= rleft_nxt;
    val_r        <= val_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    res_elem_r   <= res_elem_nxt;
    if (load) begin
      out_status_r <= res_status_r;
      out_pos_r    <= res_pos_r;
      out_elem_r   <= res_elem_r;
      out_count_r  <= POS_W'(count_r);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.found_position = out_pos_r;
  assign out_ch.element        = out_elem_r;
  assign out_ch.count          = out_count_r;

  // checks
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("list count above capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("accepted word did not start an operation");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(count_r))
    else $error("count changed without an accepted word");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status != ST_OK)) |->
      ((out_ch.found_position == '0) && (out_ch.element == '0)))
    else $error("error result carries a position or element");

endmodule

`default_nettype wire

// File: rtl/core/plst_store.sv
//------------------------------------------------------------------------------
// plst_store
// Entry store: one write port, one read port with registered read data.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plst_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [plst_pkg::WORD_W-1:0] wr_data,
  input  wire logic                       rd_en,
  input  wire logic [AW-1:0]              rd_addr,
  output      logic [plst_pkg::WORD_W-1:0] rd_data
);
  import plst_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: bench/tb_positional_list_store_core.sv
//------------------------------------------------------------------------------
// tb_positional_list_store_core
// Self-checking bench for the positional list store. A directed opening walks
// the error cases, duplicates and the last-entry find. Then random operations
// run with grow and shrink bias so that the list fills to capacity and drains
// back to empty. Every accepted operation word runs through a behavioral list
// model, and each result word is checked field by field against it. Both
// channels idle at random.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_positional_list_store_core;
  import plst_pkg::*;

  localparam int LIST_CAP    = 256;
  localparam int RANDOM_OPS  = 1300;
  localparam int IDLE_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 300;

  typedef struct {
    opcode_t          opcode;
    logic [POS_W-1:0] position;
    logic [WORD_W-1:0] value;
  } op_word_t;

  typedef struct {
    status_t           status;
    logic [POS_W-1:0]  found_position;
    logic [WORD_W-1:0] element;
    logic [POS_W-1:0]  count;
  } res_word_t;

  typedef enum {MIXED, GROW, SHRINK} bias_t;

  logic clk = 1'b0;
  logic rst_n;

  plst_in_if  op_ch ();
  plst_out_if res_ch ();

  positional_list_store_core #(.CAPACITY(LIST_CAP)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (op_ch),
    .out_ch (res_ch)
  );

  always #10 clk = ~clk;

  // list model state
  logic [WORD_W-1:0] list_words [LIST_CAP];
  int                list_len = 0;

  op_word_t  ops_to_send [$];
  res_word_t results_due [$];
  int        ops_queued = 0;
  int        ops_taken_count = 0;
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        send_gap = 0;
  int        recv_gap = 0;
  bit        op_taken = 1'b0;
  bit        res_taken = 1'b0;
  bit        quiet_send = 1'b0;
  bit        quiet_recv = 1'b0;

  function automatic res_word_t list_apply(op_word_t w);
    res_word_t r;
    int p;
    int n;
    int i;
    bit hit;
    r.status = ST_BAD;
    r.found_position = '0;
    r.element = '0;
    n = list_len;
    p = w.position;
    hit = 1'b0;
    case (w.opcode)
      OP_INSERT, OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (w.opcode == OP_PUSH_FRONT) p = 1;
        else if (w.opcode == OP_PUSH_BACK) p = n + 1;
        if (p < 1 || p > n + 1) begin
          r.status = ST_BAD;
        end else if (n >= LIST_CAP) begin
          r.status = ST_FULL;
        end else begin
          for (i = n; i >= p; i--) list_words[i] = list_words[i-1];
          list_words[p-1] = w.value;
          list_len = n + 1;
          r.status = ST_OK;
          r.found_position = p[POS_W-1:0];
          r.element = w.value;
        end
      end
      OP_ERASE, OP_POP_FRONT, OP_POP_BACK: begin
        if (w.opcode == OP_POP_FRONT) p = 1;
        else if (w.opcode == OP_POP_BACK) p = n;
        if (p >= 1 && p <= n) begin
          r.element = list_words[p-1];
          for (i = p; i < n; i++) list_words[i-1] = list_words[i];
          list_len = n - 1;
          r.status = ST_OK;
          r.found_position = p[POS_W-1:0];
        end
      end
      OP_FIND: begin
        r.status = ST_MISS;
        for (i = 0; i < n; i++) begin
          if (!hit && list_words[i] == w.value) begin
            hit = 1'b1;
            r.status = ST_OK;
            r.found_position = 9'(i + 1);
            r.element = w.value;
          end
        end
      end
      OP_MODIFY, OP_READ: begin
        if (p >= 1 && p <= n) begin
          if (w.opcode == OP_MODIFY) list_words[p-1] = w.value;
          r.status = ST_OK;
          r.found_position = p[POS_W-1:0];
          r.element = list_words[p-1];
        end
      end
      default: ;
    endcase
    r.count = 9'(list_len);
    return r;
  endfunction

  function automatic int draw_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic check_result(res_word_t got);
    res_word_t want;
    if (results_due.size() == 0) begin
      $error("result word with no operation outstanding");
      mismatches++;
    end else begin
      want = results_due.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.found_position !== want.found_position) begin
        $error("found_position: expected %0d, got %0d", want.found_position,
               got.found_position);
        mismatches++;
      end
      if (got.element !== want.element) begin
        $error("element: expected %08h, got %08h", want.element, got.element);
        mismatches++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, got.count);
        mismatches++;
      end
    end
  endtask

  // sample both channels, predict, check, watchdog
  always @(posedge clk) begin
    op_word_t  w;
    res_word_t got;
    op_taken = op_ch.valid && op_ch.ready;
    res_taken = res_ch.valid && res_ch.ready;
    if (rst_n) begin
      if (op_taken) begin
        w.opcode = op_ch.opcode;
        w.position = op_ch.position;
        w.value = op_ch.value;
        results_due.push_back(list_apply(w));
        ops_taken_count++;
        if (ops_taken_count % 64 == 0) begin
          quiet_send <= ($urandom_range(0, 3) == 0);
          quiet_recv <= ($urandom_range(0, 3) == 0);
        end
      end
      if (res_taken) begin
        got.status = res_ch.status;
        got.found_position = res_ch.found_position;
        got.element = res_ch.element;
        got.count = res_ch.count;
        check_result(got);
      end
      if (op_taken || res_taken) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  // operation word driver
  always @(negedge clk) begin
    op_word_t w;
    if (!rst_n) begin
      op_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (op_ch.valid && !op_taken) begin
      ;
    end else if (send_gap != 0) begin
      op_ch.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (ops_to_send.size() != 0) begin
      w = ops_to_send.pop_front();
      op_ch.opcode <= w.opcode;
      op_ch.position <= w.position;
      op_ch.value <= w.value;
      op_ch.valid <= 1'b1;
      send_gap <= draw_gap(quiet_send);
    end else begin
      op_ch.valid <= 1'b0;
    end
  end

  // result word receiver
  always @(negedge clk) begin
    int g;
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      recv_gap <= 0;
    end else if (res_taken) begin
      g = draw_gap(quiet_recv);
      res_ch.ready <= (g == 0);
      recv_gap <= (g == 0) ? 0 : g - 1;
    end else if (recv_gap != 0) begin
      res_ch.ready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  task automatic send_op(opcode_t op, int pos, logic [WORD_W-1:0] val);
    op_word_t w;
    w.opcode = op;
    w.position = pos[POS_W-1:0];
    w.value = val;
    ops_to_send.push_back(w);
    ops_queued++;
  endtask

  task automatic wait_taken();
    while (ops_taken_count != ops_queued) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (ops_taken_count != ops_queued || results_due.size() != 0) @(negedge clk);
  endtask

  function automatic opcode_t any_op();
    int r;
    r = $urandom_range(0, 29);
    if (r >= 27) return opcode_t'(4'($urandom_range(9, 15)));
    return opcode_t'(4'(r / 3));
  endfunction

  function automatic int pick_pos(int limit);
    int r;
    r = $urandom_range(0, 9);
    if (r < 8 && limit >= 1) return $urandom_range(1, limit);
    if (r < 9) return $urandom_range(0, 1) ? 0 : $urandom_range(limit + 1, 511);
    return $urandom_range(0, 511);
  endfunction

  function automatic logic [WORD_W-1:0] pick_value();
    logic [WORD_W-1:0] pool [4];
    pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000};
    if ($urandom_range(0, 3) == 0) return pool[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  initial begin
    op_ch.valid = 1'b0;
    op_ch.opcode = OP_READ;
    op_ch.position = '0;
    op_ch.value = '0;
    res_ch.ready = 1'b0;
    rst_n = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    bias_t             bias;
    opcode_t           op;
    logic [WORD_W-1:0] val;
    int                k;
    int                roll;
    int                limit;
    int                edge_hits;
    int                mixed_run;
    bias = MIXED;
    edge_hits = 0;
    mixed_run = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);

    // empty list errors
    send_op(OP_READ, 1, 32'h0);
    send_op(OP_POP_FRONT, 0, 32'h0);
    send_op(OP_POP_BACK, 0, 32'h0);
    send_op(OP_ERASE, 0, 32'h0);
    send_op(OP_FIND, 0, 32'h0);
    send_op(OP_INSERT, 0, 32'h0000_1111);
    send_op(OP_INSERT, 2, 32'h0000_2222);
    // build [A5A55A5A, 80000001, 0, FFFFFFFF, 12345678]
    send_op(OP_INSERT, 1, 32'h0000_0000);
    send_op(OP_PUSH_BACK, 0, 32'hFFFF_FFFF);
    send_op(OP_PUSH_FRONT, 511, 32'hA5A5_5A5A);
    send_op(OP_INSERT, 4, 32'h1234_5678);
    send_op(OP_INSERT, 2, 32'h8000_0001);
    send_op(OP_READ, 5, 32'h0);
    send_op(OP_READ, 6, 32'h0);
    send_op(OP_READ, 511, 32'h0);
    // duplicate at the head, find returns the first one
    send_op(OP_MODIFY, 1, 32'hFFFF_FFFF);
    send_op(OP_FIND, 0, 32'hFFFF_FFFF);
    send_op(OP_FIND, 3, 32'h1234_5678);
    send_op(OP_FIND, 0, 32'hDEAD_BEEF);
    send_op(OP_ERASE, 3, 32'h0);
    send_op(OP_ERASE, 5, 32'h0);
    send_op(OP_MODIFY, 0, 32'h5555_5555);
    send_op(opcode_t'(4'd9), 1, 32'hFFFF_FFFF);
    send_op(opcode_t'(4'd15), 511, 32'hFFFF_FFFF);
    send_op(OP_POP_FRONT, 0, 32'h0);
    send_op(OP_POP_BACK, 0, 32'h0);

    for (k = 0; k < RANDOM_OPS; k++) begin
      wait_taken();
      if (bias == MIXED && mixed_run >= 150) begin
        wait_drained();
        bias = GROW;
        edge_hits = 0;
      end else if (bias == GROW && edge_hits >= 40) begin
        wait_drained();
        bias = SHRINK;
        edge_hits = 0;
      end else if (bias == SHRINK && edge_hits >= 15) begin
        wait_drained();
        bias = MIXED;
        mixed_run = 0;
      end
      roll = $urandom_range(0, 99);
      case (bias)
        GROW: begin
          op = roll < 40 ? OP_PUSH_BACK : roll < 60 ? OP_PUSH_FRONT :
               roll < 88 ? OP_INSERT : any_op();
          if (list_len == LIST_CAP) edge_hits++;
        end
        SHRINK: begin
          op = roll < 35 ? OP_POP_BACK : roll < 55 ? OP_POP_FRONT :
               roll < 85 ? OP_ERASE : any_op();
          if (list_len == 0) edge_hits++;
        end
        default: begin
          op = any_op();
          mixed_run++;
        end
      endcase
      limit = (op == OP_INSERT) ? list_len + 1 : list_len;
      if (op == OP_FIND && list_len != 0 && $urandom_range(0, 1))
        val = list_words[$urandom_range(0, list_len - 1)];
      else
        val = pick_value();
      send_op(op, pick_pos(limit), val);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
